@@ sv/tqi_pkg.sv @@
// Package for the table quadratic interpolator: widths, codes and item types.
// Used by table_quadratic_interpolator; depends on nothing.
package tqi_pkg;

	localparam int DATA_W      = 32;
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int PROD_W      = 2 * DATA_W;
	localparam int NUM_W       = 3 * DATA_W;
	localparam int ACC_W       = NUM_W + 3;
	localparam int DIV_CNT_W   = $clog2(NUM_W);
	localparam int STATUS_W    = 2;
	localparam int MIN_POINTS  = 3;

	localparam logic [CNT_W-1:0] POINTS_RESET = CNT_W'(TABLE_DEPTH);

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SATURATED  = 2'd2;

	typedef struct packed {
		logic                     func;
		logic [3:0]               entry_index;
		logic signed [DATA_W-1:0] entry_abscissa;
		logic signed [DATA_W-1:0] entry_ordinate;
		logic signed [DATA_W-1:0] query_x;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [STATUS_W-1:0]      status;
	} result_t;

endpackage

@@ sv/table_quadratic_interpolator.sv @@
// Top level of the table quadratic interpolator: point table memory, search and
// Lagrange evaluation sequencer with a restoring divider. Depends on tqi_pkg.

// A load item writes one table point and returns its result (value 0, status ok)
// in the cycle after start; busy stays low. A query reads the outer table points
// (S_CHK0, S_CHKN), runs up to 4 binary search steps (S_SRCH, S_SCMP), reads and
// checks the three chosen points (S_F0 to S_F3, S_DEG), then handles 3 terms:
// operands formed and multiplied (S_T0 to S_T4), the one-bit-per-cycle restoring
// divider over a 96-bit numerator (S_DIV), a round (S_RND), an accumulate (S_ACC);
// it saturates in S_OUT. A query ends early on an exact hit or a degenerate
// spacing and skips the search for an x outside the table. The result shows for
// one cycle, the cycle in which busy falls, with done high and must be taken
// then; a new item may start in that same cycle. The table has no reset:
// queries must only touch points that were loaded.
module table_quadratic_interpolator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tqi_pkg::cmd_t   cmd,
	output logic            busy,
	input  logic            cfg_we,
	input  logic [4:0]      cfg_wdata,
	output logic            done,
	output tqi_pkg::result_t result
);
	import tqi_pkg::*;

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] S_IDLE = 5'd0;
	localparam logic [ST_W-1:0] S_CHK0 = 5'd1;
	localparam logic [ST_W-1:0] S_CHKN = 5'd2;
	localparam logic [ST_W-1:0] S_SRCH = 5'd3;
	localparam logic [ST_W-1:0] S_SCMP = 5'd4;
	localparam logic [ST_W-1:0] S_F0   = 5'd5;
	localparam logic [ST_W-1:0] S_F1   = 5'd6;
	localparam logic [ST_W-1:0] S_F2   = 5'd7;
	localparam logic [ST_W-1:0] S_F3   = 5'd8;
	localparam logic [ST_W-1:0] S_DEG  = 5'd9;
	localparam logic [ST_W-1:0] S_T0   = 5'd10;
	localparam logic [ST_W-1:0] S_T1   = 5'd11;
	localparam logic [ST_W-1:0] S_T2   = 5'd12;
	localparam logic [ST_W-1:0] S_T3   = 5'd13;
	localparam logic [ST_W-1:0] S_T4   = 5'd14;
	localparam logic [ST_W-1:0] S_DIV  = 5'd15;
	localparam logic [ST_W-1:0] S_RND  = 5'd16;
	localparam logic [ST_W-1:0] S_ACC  = 5'd17;
	localparam logic [ST_W-1:0] S_OUT  = 5'd18;

	localparam logic [1:0] LAST_TERM = 2'd2;

	logic [2*DATA_W-1:0] mem [TABLE_DEPTH];
	logic [2*DATA_W-1:0] rd_q;
	logic [IDX_W-1:0]    rd_addr;
	logic                mem_we;

	logic [ST_W-1:0]  state_q;
	logic [CNT_W-1:0] points_q;
	logic [CNT_W-1:0] n_q;
	logic signed [DATA_W-1:0] x_q;
	logic [IDX_W-1:0] k1_q, k2_q, mid_q;
	logic signed [DATA_W-1:0] b1_q, b2_q, b3_q, f1_q, f2_q, f3_q;
	logic [1:0]       term_q;
	logic [DATA_W-1:0] mn1_q, mn2_q, md1_q, md2_q, mf_q;
	logic             neg_q;
	logic [PROD_W-1:0] nm_q, dm_q, pplo_q, pphi_q;
	logic [NUM_W-1:0]  num_q, qr_q;
	logic [PROD_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic signed [ACC_W-1:0] sum_q;
	logic             done_q;
	result_t          res_q;

	logic signed [DATA_W-1:0] rd_absc, rd_ord;
	logic [CNT_W-1:0] n_clamp;
	logic [IDX_W-1:0] n_last, n_low, span, mid;
	logic signed [DATA_W-1:0] sf, sp1, sp2, sq1, sq2;
	logic signed [DATA_W:0] dn1, dn2, dd1, dd2;
	logic [DATA_W:0] an1, an2, ad1, ad2, af;
	logic [PROD_W:0] trial;
	logic [PROD_W:0] rem_sh;

	assign rd_absc = rd_q[2*DATA_W-1:DATA_W];
	assign rd_ord  = rd_q[DATA_W-1:0];
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign result  = res_q;
	assign mem_we  = start && !busy && (cmd.func == FUNC_LOAD);

	always_comb begin
		if (points_q < CNT_W'(MIN_POINTS)) begin
			n_clamp = CNT_W'(MIN_POINTS);
		end else if (points_q > CNT_W'(TABLE_DEPTH)) begin
			n_clamp = CNT_W'(TABLE_DEPTH);
		end else begin
			n_clamp = points_q;
		end
	end

	assign n_last = IDX_W'(n_q - CNT_W'(1));
	assign n_low  = IDX_W'(n_q - CNT_W'(MIN_POINTS));
	assign span   = k2_q - k1_q;
	assign mid    = k1_q + (span >> 1);

	always_comb begin
		unique case (state_q)
			S_CHK0:  rd_addr = n_last;
			S_SRCH:  rd_addr = mid;
			S_F0:    rd_addr = k1_q;
			S_F1:    rd_addr = k1_q + IDX_W'(1);
			S_F2:    rd_addr = k1_q + IDX_W'(2);
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		unique case (term_q)
			2'd0: begin
				sf = f1_q; sp1 = b2_q; sp2 = b3_q; sq1 = b1_q; sq2 = b1_q;
			end
			2'd1: begin
				sf = f2_q; sp1 = b1_q; sp2 = b3_q; sq1 = b2_q; sq2 = b2_q;
			end
			default: begin
				sf = f3_q; sp1 = b1_q; sp2 = b2_q; sq1 = b3_q; sq2 = b3_q;
			end
		endcase
		dn1 = {x_q[DATA_W-1], x_q} - {sp1[DATA_W-1], sp1};
		dn2 = {x_q[DATA_W-1], x_q} - {sp2[DATA_W-1], sp2};
		dd1 = {sq1[DATA_W-1], sq1} - {sp1[DATA_W-1], sp1};
		dd2 = {sq2[DATA_W-1], sq2} - {sp2[DATA_W-1], sp2};
		an1 = dn1[DATA_W] ? -dn1 : dn1;
		an2 = dn2[DATA_W] ? -dn2 : dn2;
		ad1 = dd1[DATA_W] ? -dd1 : dd1;
		ad2 = dd2[DATA_W] ? -dd2 : dd2;
		af  = sf[DATA_W-1] ? -{sf[DATA_W-1], sf} : {sf[DATA_W-1], sf};
	end

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign trial  = rem_sh - {1'b0, dm_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cmd.entry_index[IDX_W-1:0]] <= {cmd.entry_abscissa, cmd.entry_ordinate};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= POINTS_RESET;
		end else if (cfg_we) begin
			points_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			term_q  <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd.func == FUNC_LOAD) begin
							res_q  <= '{value: '0, status: STATUS_OK};
							done_q <= 1'b1;
						end else begin
							x_q     <= cmd.query_x;
							n_q     <= n_clamp;
							state_q <= S_CHK0;
						end
					end
				end
				S_CHK0: begin
					if (x_q < rd_absc) begin
						k1_q    <= '0;
						state_q <= S_F0;
					end else begin
						state_q <= S_CHKN;
					end
				end
				S_CHKN: begin
					if (x_q > rd_absc) begin
						k1_q    <= n_low;
						state_q <= S_F0;
					end else begin
						k1_q    <= '0;
						k2_q    <= n_last;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (span > IDX_W'(1)) begin
						mid_q   <= mid;
						state_q <= S_SCMP;
					end else begin
						if (k2_q == n_last) begin
							k1_q <= n_low;
						end
						state_q <= S_F0;
					end
				end
				S_SCMP: begin
					priority if (rd_absc == x_q) begin
						res_q   <= '{value: rd_ord, status: STATUS_OK};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (rd_absc < x_q) begin
						k1_q    <= mid_q;
						state_q <= S_SRCH;
					end else begin
						k2_q    <= mid_q;
						state_q <= S_SRCH;
					end
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					b1_q    <= rd_absc;
					f1_q    <= rd_ord;
					state_q <= S_F2;
				end
				S_F2: begin
					b2_q    <= rd_absc;
					f2_q    <= rd_ord;
					state_q <= S_F3;
				end
				S_F3: begin
					b3_q    <= rd_absc;
					f3_q    <= rd_ord;
					state_q <= S_DEG;
				end
				S_DEG: begin
					if (b1_q == b2_q || b1_q == b3_q || b2_q == b3_q) begin
						res_q   <= '{value: '0, status: STATUS_DEGENERATE};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						term_q  <= '0;
						sum_q   <= '0;
						state_q <= S_T0;
					end
				end
				S_T0: begin
					mn1_q   <= an1[DATA_W-1:0];
					mn2_q   <= an2[DATA_W-1:0];
					md1_q   <= ad1[DATA_W-1:0];
					md2_q   <= ad2[DATA_W-1:0];
					mf_q    <= af[DATA_W-1:0];
					neg_q   <= sf[DATA_W-1] ^ dn1[DATA_W] ^ dn2[DATA_W]
						^ dd1[DATA_W] ^ dd2[DATA_W];
					state_q <= S_T1;
				end
				S_T1: begin
					nm_q    <= mn1_q * mn2_q;
					dm_q    <= md1_q * md2_q;
					state_q <= S_T2;
				end
				S_T2: begin
					pplo_q  <= mf_q * nm_q[DATA_W-1:0];
					state_q <= S_T3;
				end
				S_T3: begin
					pphi_q  <= mf_q * nm_q[PROD_W-1:DATA_W];
					state_q <= S_T4;
				end
				S_T4: begin
					num_q   <= {{DATA_W{1'b0}}, pplo_q} + {pphi_q, {DATA_W{1'b0}}};
					rem_q   <= '0;
					cnt_q   <= DIV_CNT_W'(NUM_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!trial[PROD_W]) begin
						rem_q <= trial[PROD_W-1:0];
						num_q <= {num_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[PROD_W-1:0];
						num_q <= {num_q[NUM_W-2:0], 1'b0};
					end
					if (cnt_q == '0) begin
						state_q <= S_RND;
					end else begin
						cnt_q <= cnt_q - DIV_CNT_W'(1);
					end
				end
				S_RND: begin
					qr_q    <= num_q + NUM_W'({rem_q, 1'b0} >= {1'b0, dm_q});
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (neg_q) begin
						sum_q <= sum_q - $signed({3'b000, qr_q});
					end else begin
						sum_q <= sum_q + $signed({3'b000, qr_q});
					end
					if (term_q == LAST_TERM) begin
						state_q <= S_OUT;
					end else begin
						term_q  <= term_q + 2'd1;
						state_q <= S_T0;
					end
				end
				S_OUT: begin
					priority if (!sum_q[ACC_W-1] && (|sum_q[ACC_W-2:DATA_W-1])) begin
						res_q <= '{value: {1'b0, {(DATA_W-1){1'b1}}},
							status: STATUS_SATURATED};
					end else if (sum_q[ACC_W-1] && !(&sum_q[ACC_W-2:DATA_W-1])) begin
						res_q <= '{value: {1'b1, {(DATA_W-1){1'b0}}},
							status: STATUS_SATURATED};
					end else begin
						res_q <= '{value: sum_q[DATA_W-1:0], status: STATUS_OK};
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.func == FUNC_QUERY) |=> busy)
		else $error("query item did not start");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.func == FUNC_LOAD) |=> (done && result.value == '0))
		else $error("load item gave no zero result");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STATUS_DEGENERATE) |-> (result.value == '0))
		else $error("degenerate result not zero");
`endif

endmodule
